// ===== hdl/pdq_pkg.sv =====
`default_nettype none

package pdq_pkg;

    // Sizing defaults.
    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CMDQ_DEPTH_DEF  = 2;

    // Framing bytes.
    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;

    // Item kinds as they arrive on the input channel.
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [1:0] REG_TYPE_FLOOR       = 2'd1;
    localparam logic [1:0] REG_TYPE_CEILING     = 2'd2;
    localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd3;

    typedef enum logic [1:0] {
        OP_RX,
        OP_READ,
        OP_POP,
        OP_NOP
    } pdq_op_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ACCEPT = 3'd1,
        EV_DROP   = 3'd2,
        EV_PARSE  = 3'd3,
        EV_CSUM   = 3'd4,
        EV_POP    = 3'd5,
        EV_EMPTY  = 3'd6,
        EV_DATA   = 3'd7
    } pdq_event_t;

    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_VER,
        PH_TYPE,
        PH_LEN,
        PH_PAY,
        PH_CSUM
    } pdq_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [4:0] byte_index;
    } pdq_in_t;

    typedef struct packed {
        pdq_event_t  event_res;
        logic [7:0]  msg_type;
        logic [5:0]  frame_len;
        logic [7:0]  data_byte;
        logic [2:0]  queue_count;
        logic [31:0] frames_received;
        logic [31:0] frames_dropped;
        logic [31:0] format_errors;
        logic [31:0] checksum_fails;
    } pdq_out_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        pdq_op_t    op;
        logic [7:0] rx_byte;
        logic [4:0] byte_index;
    } pdq_cmd_t;

    typedef struct packed {
        logic [7:0] expected_version;
        logic [7:0] type_floor;
        logic [7:0] type_ceiling;
        logic [5:0] max_payload;
    } pdq_cfg_t;

    // Command queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } pdq_qstat_t;

endpackage

`default_nettype wire

// ===== hdl/pdq_front.sv =====
`default_nettype none

module pdq_front (
    input  wire                  item_valid,
    input  pdq_pkg::pdq_in_t     item,
    input  pdq_pkg::pdq_qstat_t  qstat,
    output logic                 item_stall,
    output logic                 push,
    output pdq_pkg::pdq_cmd_t    cmd
);

    // The command queue status is registered, so the stall never depends on valid.
    assign item_stall = qstat.full;
    assign push       = item_valid && !qstat.full;

    always_comb
    begin
        cmd.rx_byte    = item.rx_byte;
        cmd.byte_index = item.byte_index;
        case (item.kind)
            pdq_pkg::KIND_RX:   cmd.op = pdq_pkg::OP_RX;
            pdq_pkg::KIND_READ: cmd.op = pdq_pkg::OP_READ;
            pdq_pkg::KIND_POP:  cmd.op = pdq_pkg::OP_POP;
            default:            cmd.op = pdq_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pdq_cmdq.sv =====
`default_nettype none

module pdq_cmdq #(
    parameter int DEPTH = pdq_pkg::CMDQ_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  pdq_pkg::pdq_cmd_t    push_cmd,
    input  wire                  pop,
    output pdq_pkg::pdq_qstat_t  qstat,
    output pdq_pkg::pdq_cmd_t    head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pdq_pkg::pdq_cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_cmd    = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hdl/pdq_back.sv =====
`default_nettype none

module pdq_back #(
    parameter int MAX_PAYLOAD = pdq_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = pdq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire  [1:0]           cfg_index,
    input  wire  [7:0]           cfg_data,
    input  pdq_pkg::pdq_qstat_t  qstat,
    input  pdq_pkg::pdq_cmd_t    cmd,
    output logic                 pop,
    output logic                 result_valid,
    input  wire                  result_stall,
    output pdq_pkg::pdq_out_t    result
);

    localparam int MEM_DEPTH = QUEUE_DEPTH * MAX_PAYLOAD;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW        = $clog2(QUEUE_DEPTH + 1);

    // Configuration.
    pdq_pkg::pdq_cfg_t cfg_reg;

    // Parser state.
    pdq_pkg::pdq_phase_t phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] cur_type_reg, cur_type_next;
    logic [5:0] cur_len_reg, cur_len_next;
    logic [5:0] cur_pos_reg, cur_pos_next;
    logic       spill_reg, spill_next;

    // Frame ring.
    logic [7:0]    slot_type [QUEUE_DEPTH];
    logic [5:0]    slot_len  [QUEUE_DEPTH];
    logic [7:0]    payload_mem [MEM_DEPTH];
    logic [QW-1:0] head_reg, head_next;
    logic [QW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    // Statistics.
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] drop_reg, drop_next;
    logic [31:0] fmt_reg, fmt_next;
    logic [31:0] csum_reg, csum_next;

    // Output register.
    logic              out_valid_reg;
    pdq_pkg::pdq_out_t res_reg;
    logic              data_sel_reg;
    logic [7:0]        rdata_reg;

    pdq_pkg::pdq_event_t ev;
    logic [7:0]    res_type;
    logic [5:0]    res_len;
    logic          slot_we;
    logic          mem_we;
    logic          rd_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    len_limit;
    logic          go_hunt;
    logic [7:0]    b;

    assign pop = !qstat.empty && (!out_valid_reg || !result_stall);
    assign b   = cmd.rx_byte;

    assign len_limit = (8'(cfg_reg.max_payload) < 8'(MAX_PAYLOAD))
                     ? 8'(cfg_reg.max_payload) : 8'(MAX_PAYLOAD);
    assign waddr = AW'(tail_reg) * AW'(MAX_PAYLOAD) + AW'(cur_pos_reg);
    assign raddr = AW'(head_reg) * AW'(MAX_PAYLOAD) + AW'(cmd.byte_index);

    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        cur_type_next = cur_type_reg;
        cur_len_next  = cur_len_reg;
        cur_pos_next  = cur_pos_reg;
        spill_next    = spill_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        rcv_next      = rcv_reg;
        drop_next     = drop_reg;
        fmt_next      = fmt_reg;
        csum_next     = csum_reg;
        ev            = pdq_pkg::EV_NONE;
        res_type      = '0;
        res_len       = '0;
        slot_we       = 1'b0;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        go_hunt       = 1'b0;

        case (cmd.op)
            pdq_pkg::OP_RX:
            begin
                case (phase_reg)
                    pdq_pkg::PH_HUNT0:
                    begin
                        if (b == pdq_pkg::SYNC_A)
                        begin
                            phase_next = pdq_pkg::PH_HUNT1;
                        end
                    end
                    pdq_pkg::PH_HUNT1:
                    begin
                        if (b == pdq_pkg::SYNC_B)
                        begin
                            phase_next = pdq_pkg::PH_VER;
                        end
                        else if (b != pdq_pkg::SYNC_A)
                        begin
                            go_hunt = 1'b1;
                        end
                    end
                    pdq_pkg::PH_VER:
                    begin
                        if (b != cfg_reg.expected_version)
                        begin
                            fmt_next = fmt_reg + 32'd1;
                            ev       = pdq_pkg::EV_PARSE;
                            go_hunt  = 1'b1;
                        end
                        else
                        begin
                            xor_next   = b;
                            phase_next = pdq_pkg::PH_TYPE;
                        end
                    end
                    pdq_pkg::PH_TYPE:
                    begin
                        if (b <= cfg_reg.type_floor || b >= cfg_reg.type_ceiling)
                        begin
                            fmt_next = fmt_reg + 32'd1;
                            ev       = pdq_pkg::EV_PARSE;
                            go_hunt  = 1'b1;
                        end
                        else
                        begin
                            cur_type_next = b;
                            xor_next      = xor_reg ^ b;
                            phase_next    = pdq_pkg::PH_LEN;
                        end
                    end
                    pdq_pkg::PH_LEN:
                    begin
                        if (b > len_limit)
                        begin
                            fmt_next = fmt_reg + 32'd1;
                            ev       = pdq_pkg::EV_PARSE;
                            go_hunt  = 1'b1;
                        end
                        else
                        begin
                            cur_len_next = b[5:0];
                            cur_pos_next = '0;
                            spill_next   = 1'b0;
                            xor_next     = xor_reg ^ b;
                            phase_next   = (b == 8'd0) ? pdq_pkg::PH_CSUM : pdq_pkg::PH_PAY;
                        end
                    end
                    pdq_pkg::PH_PAY:
                    begin
                        if (cur_pos_reg >= cur_len_reg)
                        begin
                            fmt_next = fmt_reg + 32'd1;
                            ev       = pdq_pkg::EV_PARSE;
                            go_hunt  = 1'b1;
                        end
                        else
                        begin
                            // With the ring full the tail slot is still owned by a
                            // queued frame, so the byte is lost and the frame spills.
                            if (fill_reg < FW'(QUEUE_DEPTH))
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                spill_next = 1'b1;
                            end
                            cur_pos_next = cur_pos_reg + 6'd1;
                            xor_next     = xor_reg ^ b;
                            if ((cur_pos_reg + 6'd1) >= cur_len_reg)
                            begin
                                phase_next = pdq_pkg::PH_CSUM;
                            end
                        end
                    end
                    pdq_pkg::PH_CSUM:
                    begin
                        if (b == xor_reg)
                        begin
                            if (spill_reg || fill_reg >= FW'(QUEUE_DEPTH))
                            begin
                                drop_next = drop_reg + 32'd1;
                                ev        = pdq_pkg::EV_DROP;
                            end
                            else
                            begin
                                slot_we   = 1'b1;
                                tail_next = (tail_reg == QW'(QUEUE_DEPTH - 1))
                                          ? '0 : tail_reg + 1'b1;
                                fill_next = fill_reg + 1'b1;
                                rcv_next  = rcv_reg + 32'd1;
                                ev        = pdq_pkg::EV_ACCEPT;
                                res_type  = cur_type_reg;
                                res_len   = cur_len_reg;
                            end
                        end
                        else
                        begin
                            csum_next = csum_reg + 32'd1;
                            ev        = pdq_pkg::EV_CSUM;
                        end
                        go_hunt = 1'b1;
                    end
                    default:
                    begin
                        fmt_next = fmt_reg + 32'd1;
                        ev       = pdq_pkg::EV_PARSE;
                        go_hunt  = 1'b1;
                    end
                endcase
            end
            pdq_pkg::OP_READ, pdq_pkg::OP_POP:
            begin
                if (fill_reg == '0)
                begin
                    ev = pdq_pkg::EV_EMPTY;
                end
                else
                begin
                    res_type = slot_type[head_reg];
                    res_len  = slot_len[head_reg];
                    if (cmd.op == pdq_pkg::OP_READ)
                    begin
                        ev = pdq_pkg::EV_DATA;
                        // Bytes past the frame's length read as zero.
                        rd_en = ({1'b0, cmd.byte_index} < slot_len[head_reg])
                             && (9'(cmd.byte_index) < 9'(MAX_PAYLOAD));
                    end
                    else
                    begin
                        ev        = pdq_pkg::EV_POP;
                        head_next = (head_reg == QW'(QUEUE_DEPTH - 1))
                                  ? '0 : head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                ev = pdq_pkg::EV_NONE;
            end
        endcase

        if (go_hunt)
        begin
            phase_next    = pdq_pkg::PH_HUNT0;
            xor_next      = '0;
            cur_type_next = '0;
            cur_len_next  = '0;
            cur_pos_next  = '0;
            spill_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.type_floor       <= 8'd0;
            cfg_reg.type_ceiling     <= 8'd16;
            cfg_reg.max_payload      <= 6'd32;
            phase_reg     <= pdq_pkg::PH_HUNT0;
            xor_reg       <= '0;
            cur_type_reg  <= '0;
            cur_len_reg   <= '0;
            cur_pos_reg   <= '0;
            spill_reg     <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rcv_reg       <= '0;
            drop_reg      <= '0;
            fmt_reg       <= '0;
            csum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pdq_pkg::REG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_data;
                    pdq_pkg::REG_TYPE_FLOOR:       cfg_reg.type_floor       <= cfg_data;
                    pdq_pkg::REG_TYPE_CEILING:     cfg_reg.type_ceiling     <= cfg_data;
                    pdq_pkg::REG_MAX_PAYLOAD:      cfg_reg.max_payload      <= cfg_data[5:0];
                    default:                       cfg_reg                  <= cfg_reg;
                endcase
            end
            if (pop)
            begin
                phase_reg    <= phase_next;
                xor_reg      <= xor_next;
                cur_type_reg <= cur_type_next;
                cur_len_reg  <= cur_len_next;
                cur_pos_reg  <= cur_pos_next;
                spill_reg    <= spill_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                fill_reg     <= fill_next;
                rcv_reg      <= rcv_next;
                drop_reg     <= drop_next;
                fmt_reg      <= fmt_next;
                csum_reg     <= csum_next;
            end
            out_valid_reg <= pop || (out_valid_reg && result_stall);
        end
    end

    // Slot records, payload memory and the result register.
    always_ff @(posedge clk)
    begin
        if (pop && slot_we)
        begin
            slot_type[tail_reg] <= cur_type_reg;
            slot_len[tail_reg]  <= cur_len_reg;
        end
        if (pop && mem_we)
        begin
            payload_mem[waddr] <= b;
        end
        if (pop && rd_en)
        begin
            rdata_reg <= payload_mem[raddr];
        end
        if (pop)
        begin
            data_sel_reg            <= rd_en;
            res_reg.event_res       <= ev;
            res_reg.msg_type        <= res_type;
            res_reg.frame_len       <= res_len;
            res_reg.data_byte       <= '0;
            res_reg.queue_count     <= 3'(fill_next);
            res_reg.frames_received <= rcv_next;
            res_reg.frames_dropped  <= drop_next;
            res_reg.format_errors   <= fmt_next;
            res_reg.checksum_fails  <= csum_next;
        end
    end

    assign result_valid = out_valid_reg;

    always_comb
    begin
        result           = res_reg;
        result.data_byte = data_sel_reg ? rdata_reg : 8'd0;
    end

endmodule

`default_nettype wire

// ===== hdl/packet_deframer_with_queue_unit.sv =====
// Byte-stream frame parser with a small frame ring. Each item is one of three
// kinds: a received byte, which is fed to a parser that hunts for the sync pair
// 0xAA 0x55 and then checks version, message type and length, collects the
// payload and compares an XOR checksum; a read of one payload byte of the frame
// at the head of the ring; or a pop of that head frame. Every item returns
// exactly one result carrying the event code, frame details where they apply,
// the ring fill level and four wrapping statistics counters. The block takes
// one item per clock cycle sustained unless the output stalls, and each result
// is registered; that rate is set by the back end, which steps the parser, the
// ring pointers and the counters once per cycle and reads the payload memory
// through a single registered read port. A short command queue sits between
// the input classifier and the back end, so a stalled output only stalls the
// input once that queue has filled. Configuration registers take
// effect on the next item and are meant to be written while the block is idle.
// Payload and slot storage come up undefined and need no clearing pass after
// reset; only frames that were actually queued are ever read.
`default_nettype none

module packet_deframer_with_queue_unit #(
    parameter int MAX_PAYLOAD = pdq_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = pdq_pkg::QUEUE_DEPTH_DEF,
    parameter int CMDQ_DEPTH  = pdq_pkg::CMDQ_DEPTH_DEF
) (
    input  wire                clk,
    input  wire                rst_n,

    // Input items.
    input  wire                item_valid,
    output logic               item_stall,
    input  pdq_pkg::pdq_in_t   item,

    // Results.
    output logic               result_valid,
    input  wire                result_stall,
    output pdq_pkg::pdq_out_t  result,

    // Configuration writes.
    input  wire                cfg_we,
    input  wire  [1:0]         cfg_index,
    input  wire  [7:0]         cfg_data
);

    pdq_pkg::pdq_qstat_t qstat;
    pdq_pkg::pdq_cmd_t   push_cmd;
    pdq_pkg::pdq_cmd_t   head_cmd;
    logic                push;
    logic                pop;

    // The front end turns each accepted item into a command.
    pdq_front u_front (
        .item_valid (item_valid),
        .item       (item),
        .qstat      (qstat),
        .item_stall (item_stall),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Commands wait here until the back end can take them.
    pdq_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .qstat    (qstat),
        .head_cmd (head_cmd)
    );

    // The back end runs the parser, the frame ring and the statistics.
    pdq_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .qstat        (qstat),
        .cmd          (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hdl/pdq_checker.sv =====
`default_nettype none

module pdq_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                result_valid,
    input wire                result_stall,
    input pdq_pkg::pdq_out_t  result
);

    // A result held back by the stall must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("result changed while stalled");

    // Only a data read carries a payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_res != pdq_pkg::EV_DATA) |-> (result.data_byte == 8'd0))
        else $error("data byte set on a non-data event");

    // Frame details appear only for accepted, popped or read frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_res != pdq_pkg::EV_ACCEPT
            && result.event_res != pdq_pkg::EV_POP
            && result.event_res != pdq_pkg::EV_DATA)
        |-> (result.msg_type == 8'd0 && result.frame_len == 6'd0))
        else $error("frame details set on an event without a frame");

    // An empty report means the ring really is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_res == pdq_pkg::EV_EMPTY) |-> (result.queue_count == 3'd0))
        else $error("empty event with frames waiting");

endmodule

bind packet_deframer_with_queue_unit pdq_checker u_pdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
